/* rtl/core/psts_pkg.sv */
// ----------------------------------------------------------------------------
// psts_pkg: shared types for the priority sum tree sampler
// Field widths of the request and response, command codes and the packed
// payload structures used on both channels.
// ----------------------------------------------------------------------------
package psts_pkg;

    localparam int unsigned CMD_W = 2;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned PRI_W = 32;
    localparam int unsigned SUM_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_PUSH   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t             command;
        logic [IDX_W-1:0] leaf_index;
        logic [PRI_W-1:0] priority_req;
        logic [SUM_W-1:0] target;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] found_index;
        logic [PRI_W-1:0] leaf_priority;
        logic [SUM_W-1:0] total_sum;
    } rsp_t;

endpackage

/* rtl/core/psts_engine.sv */
// ----------------------------------------------------------------------------
// psts_engine: tree walker around the node memory
// Holds the heap-ordered sum tree in a synchronous memory and runs the
// clearing sweep, the leaf-to-root update, the root-to-leaf descent and the
// final leaf and root fetch for every request.
// ----------------------------------------------------------------------------
module psts_engine #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  psts_pkg::req_t  req_data,
    input  logic            out_free,
    output logic            res_load,
    output psts_pkg::rsp_t  res_data
);
    import psts_pkg::*;

    localparam int unsigned LW    = $clog2(LEAVES);
    localparam int unsigned NW    = LW + 1;
    localparam int unsigned NODES = 2 * LEAVES - 1;
    localparam int unsigned XW    = (LW > IDX_W) ? LW : IDX_W;

    localparam logic [NW-1:0] INNER     = NW'(LEAVES - 1);
    localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
    localparam logic [NW-1:0] ROOT      = '0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_SMP_RD,
        ST_SMP_CMP,
        ST_FIN_LEAF,
        ST_FIN_ROOT,
        ST_FIN_SUM,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [NW-1:0]    clr_reg, clr_next;
    logic [LW-1:0]    push_reg, push_next;
    logic [NW-1:0]    node_reg, node_next;
    logic [LW-1:0]    leaf_reg, leaf_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [PRI_W-1:0] pri_reg, pri_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic [SUM_W-1:0] mem [NODES];
    logic [SUM_W-1:0] rd_data_reg;
    logic             wr_en, rd_en;
    logic [NW-1:0]    wr_addr, rd_addr;
    logic [SUM_W-1:0] wr_data;

    logic             req_accept;
    logic [XW-1:0]    req_ext;
    logic [LW-1:0]    req_leaf;
    logic [NW-1:0]    req_node;
    logic [NW-1:0]    left_child;
    logic [NW-1:0]    sibling;
    logic [NW-1:0]    parent;
    logic [NW-1:0]    step;
    logic [SUM_W-1:0] sum_new;
    logic [XW-1:0]    found_ext;

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_accept = req_valid && req_ready;
    assign req_ext    = XW'(req_data.leaf_index);
    assign req_leaf   = req_ext[LW-1:0];
    assign req_node   = NW'(req_leaf) + INNER;
    assign left_child = {node_reg[NW-2:0], 1'b1};
    assign sibling    = node_reg[0] ? (node_reg + NW'(1)) : (node_reg - NW'(1));
    assign parent     = (node_reg - NW'(1)) >> 1;
    assign sum_new    = acc_reg + rd_data_reg;
    assign found_ext  = XW'(leaf_reg);

    assign res_data.found_index   = found_ext[IDX_W-1:0];
    assign res_data.leaf_priority = pri_reg;
    assign res_data.total_sum     = sum_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        push_next  = push_reg;
        node_next  = node_reg;
        leaf_next  = leaf_reg;
        acc_next   = acc_reg;
        pri_next   = pri_reg;
        sum_next   = sum_reg;
        wr_en      = 1'b0;
        wr_addr    = clr_reg;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr    = ROOT;
        res_load   = 1'b0;
        step       = left_child;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + NW'(1);
                if (clr_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    case (req_data.command)
                        CMD_WRITE:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = req_node;
                            wr_data    = SUM_W'(req_data.priority_req);
                            acc_next   = SUM_W'(req_data.priority_req);
                            node_next  = req_node;
                            leaf_next  = req_leaf;
                            state_next = ST_UP_RD;
                        end
                        CMD_SAMPLE:
                        begin
                            acc_next   = req_data.target;
                            node_next  = ROOT;
                            state_next = ST_SMP_RD;
                        end
                        CMD_PUSH:
                        begin
                            push_next  = push_reg + LW'(1);
                            leaf_next  = push_reg + LW'(1);
                            state_next = ST_FIN_LEAF;
                        end
                        default:
                        begin
                            leaf_next  = req_leaf;
                            state_next = ST_FIN_LEAF;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = sibling;
                state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = parent;
                wr_data    = sum_new;
                acc_next   = sum_new;
                node_next  = parent;
                state_next = (parent == ROOT) ? ST_FIN_LEAF : ST_UP_RD;
            end
            ST_SMP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = left_child;
                state_next = ST_SMP_CMP;
            end
            ST_SMP_CMP:
            begin
                if (acc_reg > rd_data_reg)
                begin
                    acc_next = acc_reg - rd_data_reg;
                    step     = left_child + NW'(1);
                end
                node_next = step;
                if (step >= INNER)
                begin
                    leaf_next  = LW'(step - INNER);
                    state_next = ST_FIN_LEAF;
                end
                else
                begin
                    state_next = ST_SMP_RD;
                end
            end
            ST_FIN_LEAF:
            begin
                rd_en      = 1'b1;
                rd_addr    = NW'(leaf_reg) + INNER;
                state_next = ST_FIN_ROOT;
            end
            ST_FIN_ROOT:
            begin
                pri_next   = rd_data_reg[PRI_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = ROOT;
                state_next = ST_FIN_SUM;
            end
            ST_FIN_SUM:
            begin
                sum_next   = rd_data_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            push_reg  <= '1;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            push_reg  <= push_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        leaf_reg <= leaf_next;
        acc_reg  <= acc_next;
        pri_reg  <= pri_next;
        sum_reg  <= sum_next;
    end

    // Node memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_descent_inner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SMP_RD) |-> (node_reg < INNER))
        else $error("descent reads below a leaf");

    a_climb_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_WR) |-> (node_reg != ROOT))
        else $error("update climbs past the root");

    a_push_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && (req_data.command == CMD_PUSH))
            |=> (push_reg == ($past(push_reg) + LW'(1))))
        else $error("push slot did not advance by one");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded over an untaken response");

endmodule

/* rtl/core/psts_out.sv */
// ----------------------------------------------------------------------------
// psts_out: response register
// Holds one finished response until the consumer takes it, so the walker
// can start on the next request meanwhile.
// ----------------------------------------------------------------------------
module psts_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  psts_pkg::rsp_t  res_data,
    output logic            free,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output psts_pkg::rsp_t  rsp_data
);
    import psts_pkg::*;

    logic valid_reg, valid_next;
    rsp_t data_reg;

    assign free      = !valid_reg || rsp_ready;
    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_data;
        end
    end

endmodule

/* rtl/core/priority_sum_tree_sampler_unit.sv */
// ----------------------------------------------------------------------------
// priority_sum_tree_sampler_unit: sum tree for prioritised replay sampling
// Top level: node memory walker plus a response register.
// ----------------------------------------------------------------------------
// The block keeps a binary sum tree over LEAVES unsigned Q16.16 leaf
// priorities (LEAVES a power of two), with 48-bit Q32.16 inner sums in a
// single synchronous node memory of 2*LEAVES-1 entries. Each request gives
// exactly one response. A write stores the leaf and climbs to the root,
// one sibling read and one parent write per level; a sample descends from
// the root, one left-child read and compare per level, going left when the
// target does not exceed the left sum and otherwise subtracting it and going
// right; a read returns a leaf; a push request returns the next round-robin
// slot. Leaf indices are taken modulo LEAVES. Every response also carries
// the leaf priority and the root sum after the request. After reset the
// block sweeps the node memory to zero, holding req_ready low. A write or
// a sample then walks the tree level by level and ends by fetching the
// leaf and the root; a read or a push only fetches the leaf and the root.
// A finished response waits in its own register, so the next request is
// taken while it is unread.
// ----------------------------------------------------------------------------
module priority_sum_tree_sampler_unit #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  psts_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output psts_pkg::rsp_t  rsp_data
);
    import psts_pkg::*;

    // Handover between the walker and the response register.
    logic out_free;
    logic res_load;
    rsp_t res_data;

    // Walk the tree: clearing sweep, update climb, sample descent, fetch.
    psts_engine #(
        .LEAVES (LEAVES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .out_free  (out_free),
        .res_load  (res_load),
        .res_data  (res_data)
    );

    // Hold the finished response until it is taken.
    psts_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_data  (res_data),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
